/* sv/dpcu_pkg.sv */
// ----------------------------------------------------------------------------
// dpcu_pkg
// Shared types and constants of the digital potentiometer command unit.
// ----------------------------------------------------------------------------
`default_nettype none

package dpcu_pkg;

	localparam int NUM_WIPERS = 4;
	localparam int SEL_W      = 2;
	localparam int CFG_IDX_W  = 1;

	localparam logic [7:0] OP_WRITE_POS  = 8'h0F;
	localparam logic [7:0] OP_WRITE_CTRL = 8'h55;
	localparam logic [7:0] OP_READ_CTRL  = 8'hAA;
	localparam logic [7:0] OP_READ_POS   = 8'hF0;
	localparam logic [7:0] OP_INC        = 8'hC3;
	localparam logic [7:0] OP_DEC        = 8'h99;

	localparam logic [7:0] CTRL_RESET    = 8'h0C;
	localparam logic [7:0] RELEASE_RESET = 8'd150;
	localparam logic [7:0] FEATURE_RESET = 8'hFF;
	localparam logic [7:0] POS_MAX       = 8'hFF;
	localparam logic [7:0] POS_MIN       = 8'h00;

	localparam logic [1:0] CNT_NONE = 2'd0;
	localparam logic [1:0] CNT_ONE  = 2'd1;
	localparam logic [1:0] CNT_TWO  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_CODE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FEATURE_BYTE = 1'b1;

	typedef struct packed {
		logic [7:0] confirm_byte;
		logic [7:0] data_byte;
		logic [7:0] cmd;
	} req_t;

	typedef struct packed {
		logic       bad_command;
		logic [1:0] byte_count;
		logic [7:0] second_byte;
		logic [7:0] first_byte;
	} res_t;

	typedef struct packed {
		logic                 valid;
		logic [CFG_IDX_W-1:0] index;
		logic [7:0]           data;
	} cfg_wr_t;

endpackage

`default_nettype wire

/* sv/digital_potentiometer_command_unit.sv */
// ----------------------------------------------------------------------------
// digital_potentiometer_command_unit
// Each request passes the input register, then the result register; a stalled
// result holds it in the input register. Throughput: one request per cycle
// unless the output stalls; the wiper and control update is one
// read-modify-write of small registers between the two stages.
// Input accepted while a result waits only when the input register is empty.
// Reset: control byte 0x0C, wipers 0, release code 150, feature byte 0xFF.
// ----------------------------------------------------------------------------
`default_nettype none

module digital_potentiometer_command_unit (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [23:0]                    s_tdata,   // cmd, data_byte, confirm_byte
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [23:0]                         m_tdata,   // first_byte, second_byte, byte_count
	output logic                                m_tuser,   // bad_command
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [dpcu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [7:0]                     cfg_data
);
	import dpcu_pkg::*;

	logic    valid_s1;
	req_t    req_s1;
	logic    valid_s2;
	res_t    res_s2;
	res_t    res_comb;
	logic    out_free;
	logic    fire;
	cfg_wr_t cfg;

	assign out_free  = !valid_s2 || m_tready;
	assign fire      = valid_s1 && out_free;
	assign s_tready  = !valid_s1 || out_free;
	assign cfg_ready = 1'b1;

	assign cfg.valid = cfg_valid;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (out_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_s1 <= req_t'(s_tdata);
		end
		if (fire) begin
			res_s2 <= res_comb;
		end
	end

	dpcu_exec u_exec (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.req    (req_s1),
		.cfg    (cfg),
		.res    (res_comb)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'd0, res_s2.byte_count, res_s2.second_byte, res_s2.first_byte};
	assign m_tuser  = res_s2.bad_command;

endmodule

`default_nettype wire

/* sv/dpcu_exec.sv */
// ----------------------------------------------------------------------------
// dpcu_exec
// Command execution: control byte, wiper positions, configuration registers
// and the result for the request held in the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module dpcu_exec (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,
	input  wire dpcu_pkg::req_t    req,
	input  wire dpcu_pkg::cfg_wr_t cfg,
	output dpcu_pkg::res_t         res
);
	import dpcu_pkg::*;

	logic [7:0]       release_q;
	logic [7:0]       feature_q;
	logic [7:0]       ctrl_q;
	logic [7:0]       wiper_q [NUM_WIPERS];

	logic [SEL_W-1:0] sel;
	logic             present;
	logic [7:0]       pos_rd;
	logic [7:0]       pos_inc;
	logic [7:0]       pos_dec;
	logic             released;
	logic [7:0]       ctrl_new;
	logic             wiper_we;
	logic [7:0]       wiper_wd;
	logic             ctrl_we;

	assign sel      = ctrl_q[SEL_W-1:0];
	assign released = (req.confirm_byte == release_q);
	assign ctrl_new = {req.data_byte[7:4], ~req.data_byte[1], ~req.data_byte[0],
		req.data_byte[1:0]};
	assign pos_inc  = (pos_rd != POS_MAX) ? pos_rd + 8'd1 : pos_rd;
	assign pos_dec  = (pos_rd != POS_MIN) ? pos_rd - 8'd1 : pos_rd;

	always_comb begin
		present = 1'b0;
		pos_rd  = 8'd0;
		for (int i = 0; i < NUM_WIPERS; i++) begin
			if (sel == SEL_W'(i)) begin
				present = 1'b1;
				pos_rd  = wiper_q[i];
			end
		end
	end

	always_comb begin
		res      = '0;
		wiper_we = 1'b0;
		wiper_wd = req.data_byte;
		ctrl_we  = 1'b0;
		unique case (req.cmd)
			OP_WRITE_POS: begin
				res.first_byte = req.data_byte;
				res.byte_count = CNT_ONE;
				wiper_we       = released;
			end
			OP_WRITE_CTRL: begin
				res.first_byte = req.data_byte;
				res.byte_count = CNT_ONE;
				ctrl_we        = released;
			end
			OP_READ_CTRL: begin
				res.first_byte  = feature_q;
				res.second_byte = ctrl_q;
				res.byte_count  = CNT_TWO;
			end
			OP_READ_POS: begin
				res.first_byte  = ctrl_q;
				res.second_byte = pos_rd;
				res.byte_count  = CNT_TWO;
			end
			OP_INC: begin
				res.first_byte = present ? pos_inc : 8'd0;
				res.byte_count = CNT_ONE;
				wiper_we       = 1'b1;
				wiper_wd       = pos_inc;
			end
			OP_DEC: begin
				res.first_byte = present ? pos_dec : 8'd0;
				res.byte_count = CNT_ONE;
				wiper_we       = 1'b1;
				wiper_wd       = pos_dec;
			end
			default: begin
				res.bad_command = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			release_q <= RELEASE_RESET;
			feature_q <= FEATURE_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_RELEASE_CODE: release_q <= cfg.data;
				CFG_FEATURE_BYTE: feature_q <= cfg.data;
				default:          release_q <= release_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= CTRL_RESET;
		end else if (fire && ctrl_we) begin
			ctrl_q <= ctrl_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_WIPERS; i++) begin
				wiper_q[i] <= 8'd0;
			end
		end else begin
			for (int i = 0; i < NUM_WIPERS; i++) begin
				if (fire && wiper_we && sel == SEL_W'(i)) begin
					wiper_q[i] <= wiper_wd;
				end
			end
		end
	end

endmodule

`default_nettype wire

/* sv/dpcu_checker.sv */
// ----------------------------------------------------------------------------
// dpcu_checker
// Port-level checks on the result stream of the command unit.
// ----------------------------------------------------------------------------
`default_nettype none

module dpcu_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [23:0] m_tdata,
	input wire logic        m_tuser
);

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[17:16] != 2'd3)
		else $error("byte count out of range");

	a_bad_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> m_tdata[17:0] == 18'd0)
		else $error("bad command carries data");

	a_unused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[17:16] != 2'd2) |-> m_tdata[15:8] == 8'd0)
		else $error("unused second byte not zero");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result changed");

endmodule

bind digital_potentiometer_command_unit dpcu_checker u_dpcu_checker (.*);

`default_nettype wire

/* test/tb_digital_potentiometer_command_unit.sv */
// ----------------------------------------------------------------------------
// tb_digital_potentiometer_command_unit
// Stream-level test of the potentiometer command unit. Commands go in through
// a queue-fed driver, a clocked monitor predicts every reply from its own
// copy of the control byte, wipers and registers and checks the replies in
// order. Phases differ in release code, feature byte and idle pattern.
// ----------------------------------------------------------------------------
module tb_digital_potentiometer_command_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import dpcu_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int NUM_PHASES     = 6;
	localparam int RANDOM_PER_PH  = 213;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [23:0]          s_tdata   = '0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [23:0]          m_tdata;
	logic                 m_tuser;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [7:0]           cfg_data  = '0;

	// predicted device state
	logic [7:0] pot_ctrl;
	logic [7:0] pot_wiper [NUM_WIPERS];
	logic [7:0] rel_code;
	logic [7:0] feat_byte;

	req_t pending_cmds [$];
	res_t due_replies [$];
	logic cmd_taken      = 1'b0;
	int   send_idle_pct  = 0;
	int   recv_stall_pct = 0;
	int   idle_cycles    = 0;
	int   errors         = 0;

	digital_potentiometer_command_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [7:0] wiper_at(logic [1:0] sel);
		if (sel < NUM_WIPERS) begin
			return pot_wiper[sel];
		end
		return 8'h00;
	endfunction

	function automatic res_t execute_command(req_t rq);
		res_t       rs;
		logic [1:0] sel;
		logic [7:0] pos;
		logic [7:0] nc;
		rs  = '0;
		sel = pot_ctrl[1:0];
		case (rq.cmd)
			OP_WRITE_POS: begin
				rs.first_byte = rq.data_byte;
				rs.byte_count = CNT_ONE;
				if (rq.confirm_byte == rel_code && sel < NUM_WIPERS) begin
					pot_wiper[sel] = rq.data_byte;
				end
			end
			OP_WRITE_CTRL: begin
				rs.first_byte = rq.data_byte;
				rs.byte_count = CNT_ONE;
				if (rq.confirm_byte == rel_code) begin
					nc       = rq.data_byte;
					nc[2]    = ~rq.data_byte[0];
					nc[3]    = ~rq.data_byte[1];
					pot_ctrl = nc;
				end
			end
			OP_READ_CTRL: begin
				rs.first_byte  = feat_byte;
				rs.second_byte = pot_ctrl;
				rs.byte_count  = CNT_TWO;
			end
			OP_READ_POS: begin
				rs.first_byte  = pot_ctrl;
				rs.second_byte = wiper_at(sel);
				rs.byte_count  = CNT_TWO;
			end
			OP_INC, OP_DEC: begin
				pos = wiper_at(sel);
				if (rq.cmd == OP_INC && pos != POS_MAX) begin
					pos = pos + 8'd1;
				end else if (rq.cmd == OP_DEC && pos != POS_MIN) begin
					pos = pos - 8'd1;
				end
				if (sel < NUM_WIPERS) begin
					pot_wiper[sel] = pos;
				end
				rs.first_byte = wiper_at(sel);
				rs.byte_count = CNT_ONE;
			end
			default: begin
				rs.bad_command = 1'b1;
			end
		endcase
		return rs;
	endfunction

	function automatic req_t random_command();
		req_t       rq;
		logic [7:0] ops [6]    = '{OP_WRITE_POS, OP_WRITE_CTRL, OP_READ_CTRL,
			OP_READ_POS, OP_INC, OP_DEC};
		logic [7:0] corner [4] = '{8'h00, 8'h01, 8'hFE, 8'hFF};
		if ($urandom_range(0, 99) < 12) begin
			rq.cmd = 8'($urandom_range(0, 255));
		end else begin
			rq.cmd = ops[$urandom_range(0, 5)];
		end
		if ($urandom_range(0, 3) == 0) begin
			rq.data_byte = corner[$urandom_range(0, 3)];
		end else begin
			rq.data_byte = 8'($urandom_range(0, 255));
		end
		if ($urandom_range(0, 99) < 65) begin
			rq.confirm_byte = rel_code;
		end else begin
			rq.confirm_byte = 8'($urandom_range(0, 255));
		end
		return rq;
	endfunction

	task automatic push_cmd(logic [7:0] c, logic [7:0] d, logic [7:0] f);
		pending_cmds.push_back(req_t'{confirm_byte: f, data_byte: d, cmd: c});
	endtask

	task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_config(logic [7:0] rel, logic [7:0] feat);
		put_reg(CFG_RELEASE_CODE, rel);
		put_reg(CFG_FEATURE_BYTE, feat);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// wait until every request is taken and every reply is back
	task automatic drain();
		while (pending_cmds.size() != 0 || s_tvalid || due_replies.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || cmd_taken) begin
				cmd_taken = 1'b0;
				if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata  <= pending_cmds.pop_front();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		res_t got;
		res_t want;
		logic moved;
		if (arst_n) begin
			moved = 1'b0;
			if (cfg_valid && cfg_ready) begin
				moved = 1'b1;
				if (cfg_index == CFG_RELEASE_CODE) begin
					rel_code = cfg_data;
				end else if (cfg_index == CFG_FEATURE_BYTE) begin
					feat_byte = cfg_data;
				end
			end
			if (s_tvalid && s_tready) begin
				moved = 1'b1;
				cmd_taken = 1'b1;
				due_replies.push_back(execute_command(req_t'(s_tdata)));
			end
			if (m_tvalid && m_tready) begin
				moved = 1'b1;
				got = {m_tuser, m_tdata[17:16], m_tdata[15:8], m_tdata[7:0]};
				if (due_replies.size() == 0) begin
					$error("unexpected reply %h", got);
					errors++;
				end else begin
					want = due_replies.pop_front();
					if (got.first_byte !== want.first_byte) begin
						$error("first_byte: expected %0h, got %0h",
							want.first_byte, got.first_byte);
						errors++;
					end
					if (got.second_byte !== want.second_byte) begin
						$error("second_byte: expected %0h, got %0h",
							want.second_byte, got.second_byte);
						errors++;
					end
					if (got.byte_count !== want.byte_count) begin
						$error("byte_count: expected %0d, got %0d",
							want.byte_count, got.byte_count);
						errors++;
					end
					if (got.bad_command !== want.bad_command) begin
						$error("bad_command: expected %0b, got %0b",
							want.bad_command, got.bad_command);
						errors++;
					end
				end
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		logic [7:0] rel_tab [NUM_PHASES];
		logic [7:0] feat_tab [NUM_PHASES];
		logic [7:0] r;
		int         ph;
		int         n;

		pot_ctrl  = CTRL_RESET;
		rel_code  = RELEASE_RESET;
		feat_byte = FEATURE_RESET;
		for (n = 0; n < NUM_WIPERS; n++) begin
			pot_wiper[n] = 8'h00;
		end
		rel_tab  = '{RELEASE_RESET, 8'h00, 8'hFF, 8'h00, 8'h5A, 8'h00};
		feat_tab = '{8'hA5, 8'h00, 8'hFF, 8'h00, 8'h3C, 8'h00};
		rel_tab[3]  = 8'($urandom_range(0, 255));
		feat_tab[3] = 8'($urandom_range(0, 255));
		rel_tab[5]  = 8'($urandom_range(0, 255));
		feat_tab[5] = 8'($urandom_range(0, 255));

		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		for (ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
				default: begin send_idle_pct = 15; recv_stall_pct = 15; end
			endcase
			set_config(rel_tab[ph], feat_tab[ph]);
			if (ph == 0) begin
				r = rel_code;
				push_cmd(OP_READ_CTRL, 8'hFF, 8'hFF);
				push_cmd(OP_READ_POS, 8'h00, 8'h00);
				push_cmd(OP_DEC, 8'h00, r);             // floor at zero
				push_cmd(OP_WRITE_POS, 8'hFE, r);
				push_cmd(OP_INC, 8'h00, 8'h00);
				push_cmd(OP_INC, 8'hFF, r);             // ceiling at 255
				push_cmd(OP_WRITE_POS, 8'h00, r ^ 8'h01); // no release
				push_cmd(OP_READ_POS, 8'h00, 8'h00);
				push_cmd(OP_WRITE_CTRL, 8'hFF, r);
				push_cmd(OP_READ_CTRL, 8'h00, 8'h00);
				push_cmd(OP_WRITE_POS, 8'h01, r);
				push_cmd(OP_DEC, 8'h00, 8'h00);
				push_cmd(OP_DEC, 8'h00, 8'h00);
				push_cmd(OP_READ_POS, 8'h00, 8'h00);
				push_cmd(OP_WRITE_CTRL, 8'h01, r);
				push_cmd(OP_WRITE_POS, 8'h80, r);
				push_cmd(OP_READ_POS, 8'h00, 8'h00);
				push_cmd(OP_WRITE_CTRL, 8'h02, r);
				push_cmd(OP_INC, 8'h00, 8'h00);
				push_cmd(OP_READ_POS, 8'h00, 8'h00);
				push_cmd(OP_WRITE_CTRL, 8'h57, r ^ 8'h80); // no release
				push_cmd(OP_READ_CTRL, 8'h00, 8'h00);
				push_cmd(8'h00, 8'hFF, 8'hFF);
				push_cmd(8'hFF, 8'h00, r);
				push_cmd(8'h0E, 8'h0F, 8'h55);
				push_cmd(OP_WRITE_CTRL, 8'h00, r);
				drain();
			end
			for (n = 0; n < RANDOM_PER_PH; n++) begin
				pending_cmds.push_back(random_command());
				if (n == RANDOM_PER_PH / 2) begin
					drain();
				end
			end
			drain();
		end

		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

/* sim.f */
sv/dpcu_pkg.sv
sv/dpcu_exec.sv
sv/digital_potentiometer_command_unit.sv
sv/dpcu_checker.sv
test/tb_digital_potentiometer_command_unit.sv
